// ----- sv/assert_macros.svh -----
// Assertion helpers for the matrix inverse block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MI4_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mi4 assertion failed");
`define MI4_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mi4 assertion failed");
`else
`define MI4_ASSERT(label, prop)
`define MI4_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- sv/mi4_pkg.sv -----
package mi4_pkg;

    localparam int AccW  = 132;
    localparam int AdjW  = 98;
    localparam int YW    = 128;
    localparam int TW    = 67;
    localparam int ProdW = 67;
    localparam int NumW  = 128;
    localparam int DenW  = 129;
    localparam int RemW  = 130;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LDY_E,
        OP_LDY_T,
        OP_LDY_A,
        OP_MAC_T,
        OP_MAC_M
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] addr;
        logic [3:0] adj_idx;
        logic       neg;
        logic [1:0] chunk;
        logic       top;
        logic       clr_t;
        logic       clr_m;
        logic       adj_wr;
        logic       det_ld;
        logic       div_start;
        logic       out_ld;
        logic       wr;
    } cmd_t;

    typedef struct packed {
        logic singular;
        logic div_done;
        logic out_space;
    } stat_t;

    // m-th index of {0..3} with x removed
    function automatic logic [1:0] other_idx(input logic [1:0] x, input logic [1:0] m);
        return (m < x) ? m : m + 2'd1;
    endfunction

endpackage

// ----- sv/matrix_inverse_4x4.sv -----
// Sequence: after a go beat the sixteen cofactors are formed on the shared
// multiplier, then the determinant, then one divide for each result entry.
// Each entry waits on the 128-step serial divider; a singular matrix skips the
// divides. Entry beats are taken only while idle, not until the last result is loaded.
// Reset: asynchronous, active low; clears control, the singular flag and the output valid only.
`include "assert_macros.svh"

module matrix_inverse_4x4 (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         row,
    input  logic [1:0]         col,
    input  logic signed [31:0] entry_value,
    input  logic               go,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         out_row,
    output logic [1:0]         out_col,
    output logic signed [31:0] inverse_value,
    output logic signed [31:0] determinant,
    output logic               singular,
    output logic               saturated,
    output logic               last
);
    import mi4_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    mi4_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .go       (go),
        .stat     (stat),
        .cmd      (cmd)
    );

    mi4_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .row           (row),
        .col           (col),
        .entry_value   (entry_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_row       (out_row),
        .out_col       (out_col),
        .inverse_value (inverse_value),
        .determinant   (determinant),
        .singular      (singular),
        .saturated     (saturated),
        .last          (last)
    );

    `MI4_ASSERT(a_sing_zero, (out_valid && singular) |-> (inverse_value == 32'sd0 && !saturated && determinant == 32'sd0))
    `MI4_ASSERT(a_run_busy, (out_valid && !last) |-> !in_ready)
    `MI4_ASSERT(a_div_busy, stat.div_done |-> !in_ready)
    `MI4_ASSERT_NEXT(a_last_done, out_valid && out_ready && last, !out_valid)

endmodule

// ----- sv/mi4_div.sv -----
module mi4_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mi4_pkg::NumW-1:0]    num,
    input  logic [mi4_pkg::DenW-1:0]    den,
    output logic                        done,
    output logic [mi4_pkg::NumW-1:0]    quot
);
    import mi4_pkg::*;

    localparam int CntW = $clog2(NumW);

    logic            busy_reg;
    logic            done_reg;
    logic [CntW-1:0] cnt_reg;
    logic [NumW-1:0] q_reg;
    logic [RemW-1:0] rem_reg;
    logic [DenW-1:0] den_reg;
    logic [RemW-1:0] r2;
    logic [RemW:0]   diff;
    logic            ge;

    // restoring division, one quotient bit per cycle
    assign r2   = {rem_reg[RemW-2:0], q_reg[NumW-1]};
    assign diff = {1'b0, r2} - {{(RemW+1-DenW){1'b0}}, den_reg};
    assign ge   = !diff[RemW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CntW'(NumW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[RemW-1:0] : r2;
            q_reg   <= {q_reg[NumW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ----- sv/mi4_dp.sv -----
module mi4_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  mi4_pkg::cmd_t       cmd,
    output mi4_pkg::stat_t      stat,
    input  logic [1:0]          row,
    input  logic [1:0]          col,
    input  logic signed [31:0]  entry_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          out_row,
    output logic [1:0]          out_col,
    output logic signed [31:0]  inverse_value,
    output logic signed [31:0]  determinant,
    output logic                singular,
    output logic                saturated,
    output logic                last
);
    import mi4_pkg::*;

    logic [31:0]      mat_reg [16];
    logic [AdjW-1:0]  adj_reg [16];
    logic [31:0]      x;
    logic [AdjW-1:0]  adj_rd;
    logic [AdjW-1:0]  adj_abs;

    logic signed [33:0] x_ext;
    logic signed [33:0] xs;
    logic [31:0]        yc;
    logic signed [32:0] yc_s;
    logic signed [ProdW-1:0] prod;

    logic [YW-1:0]    y_reg;
    logic [ProdW-1:0] prod_reg;
    logic             pv_reg;
    logic             pt_reg;
    logic [1:0]       psh_reg;
    logic [AccW-1:0]  addend;
    logic [AccW-1:0]  acc_m_reg;
    logic [TW-1:0]    acc_t_reg;

    logic [AccW-1:0]  dmag;
    logic [32:0]      det_sat;
    logic             det_neg_reg;
    logic [DenW-1:0]  det_mag_reg;
    logic [31:0]      det_out_reg;
    logic             singular_reg;

    logic             div_done;
    logic [NumW-1:0]  quot;
    logic [32:0]      inv_sat;

    logic             out_valid_reg;
    logic [1:0]       out_row_reg;
    logic [1:0]       out_col_reg;
    logic [31:0]      inv_reg;
    logic [31:0]      det_field_reg;
    logic             sing_field_reg;
    logic             sat_reg;
    logic             last_reg;

    // {clipped, value}
    function automatic logic [32:0] sat32(input logic neg, input logic hi_nz,
                                          input logic [31:0] lo);
        logic        clip;
        logic [31:0] v;
        if (neg)
        begin
            clip = hi_nz || (lo > 32'h8000_0000);
            v    = clip ? 32'h8000_0000 : (~lo + 32'd1);
        end
        else
        begin
            clip = hi_nz || lo[31];
            v    = clip ? 32'h7FFF_FFFF : lo;
        end
        return {clip, v};
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
            mat_reg[{row, col}] <= entry_value;
        if (cmd.adj_wr)
            adj_reg[cmd.adj_idx] <= acc_m_reg[AdjW-1:0];
    end

    assign x       = mat_reg[cmd.addr];
    assign adj_rd  = adj_reg[cmd.adj_idx];
    assign adj_abs = adj_rd[AdjW-1] ? (~adj_rd + 1'b1) : adj_rd;

    // multiply stage: signed entry times one 32-bit slice of y
    assign x_ext = {{2{x[31]}}, x};
    assign xs    = cmd.neg ? -x_ext : x_ext;
    assign yc    = y_reg[{cmd.chunk, 5'd0} +: 32];
    assign yc_s  = {cmd.top ? yc[31] : 1'b0, yc};
    assign prod  = xs * yc_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else
            pv_reg <= (cmd.op == OP_MAC_T) || (cmd.op == OP_MAC_M);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        pt_reg   <= (cmd.op == OP_MAC_T);
        psh_reg  <= cmd.chunk;
    end

    // accumulate stage
    assign addend = {{(AccW-ProdW){prod_reg[ProdW-1]}}, prod_reg} << {psh_reg, 5'd0};

    always_ff @(posedge clk)
    begin
        if (cmd.clr_m)
            acc_m_reg <= '0;
        else if (pv_reg && !pt_reg)
            acc_m_reg <= acc_m_reg + addend;

        if (cmd.clr_t)
            acc_t_reg <= '0;
        else if (pv_reg && pt_reg)
            acc_t_reg <= acc_t_reg + prod_reg;

        unique case (cmd.op)
            OP_LDY_E: y_reg <= {{(YW-32){x[31]}}, x};
            OP_LDY_T: y_reg <= {{(YW-TW){acc_t_reg[TW-1]}}, acc_t_reg};
            OP_LDY_A: y_reg <= {{(YW-AdjW){adj_rd[AdjW-1]}}, adj_rd};
            default:  y_reg <= y_reg;
        endcase
    end

    // determinant latch
    assign dmag    = acc_m_reg[AccW-1] ? (~acc_m_reg + 1'b1) : acc_m_reg;
    assign det_sat = sat32(acc_m_reg[AccW-1], |dmag[AccW-1:80], dmag[79:48]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            singular_reg <= 1'b0;
        else if (cmd.det_ld)
            singular_reg <= (acc_m_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.det_ld)
        begin
            det_neg_reg <= acc_m_reg[AccW-1];
            det_mag_reg <= dmag[DenW-1:0];
            det_out_reg <= det_sat[31:0];
        end
    end

    mi4_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   ({adj_abs[NumW-33:0], 32'd0}),
        .den   (det_mag_reg),
        .done  (div_done),
        .quot  (quot)
    );

    assign inv_sat = sat32(adj_rd[AdjW-1] ^ det_neg_reg, |quot[NumW-1:32], quot[31:0]);

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_ld)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_ld)
        begin
            out_row_reg    <= cmd.adj_idx[3:2];
            out_col_reg    <= cmd.adj_idx[1:0];
            last_reg       <= (cmd.adj_idx == 4'hF);
            sing_field_reg <= singular_reg;
            if (singular_reg)
            begin
                inv_reg       <= '0;
                det_field_reg <= '0;
                sat_reg       <= 1'b0;
            end
            else
            begin
                inv_reg       <= inv_sat[31:0];
                det_field_reg <= det_out_reg;
                sat_reg       <= inv_sat[32];
            end
        end
    end

    assign stat.singular  = singular_reg;
    assign stat.div_done  = div_done;
    assign stat.out_space = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign out_row       = out_row_reg;
    assign out_col       = out_col_reg;
    assign inverse_value = inv_reg;
    assign determinant   = det_field_reg;
    assign singular      = sing_field_reg;
    assign saturated     = sat_reg;
    assign last          = last_reg;

endmodule

// ----- sv/mi4_ctrl.sv -----
module mi4_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            go,
    input  mi4_pkg::stat_t  stat,
    output mi4_pkg::cmd_t   cmd
);
    import mi4_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_COF    = 6'b000010,
        S_DET    = 6'b000100,
        S_DSTART = 6'b001000,
        S_DWAIT  = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] k_reg, k_next;
    logic [1:0] n_reg, n_next;
    logic [3:0] s_reg, s_next;

    logic [1:0] rr, cc, rs0, rs1, rs2, cn, cp, cq;
    logic       par;

    // cofactor (rr, cc) feeds adjugate entry k
    assign rr  = k_reg[1:0];
    assign cc  = k_reg[3:2];
    assign rs0 = other_idx(rr, 2'd0);
    assign rs1 = other_idx(rr, 2'd1);
    assign rs2 = other_idx(rr, 2'd2);
    assign cn  = other_idx(cc, n_reg);
    assign cp  = other_idx(cc, (n_reg == 2'd0) ? 2'd1 : 2'd0);
    assign cq  = other_idx(cc, (n_reg == 2'd2) ? 2'd1 : 2'd2);
    assign par = rr[0] ^ cc[0];

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.op     = OP_NOP;
        cmd.adj_idx = k_reg;
        state_next = state_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        s_next     = s_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.wr = 1'b1;
                    if (go)
                    begin
                        state_next = S_COF;
                        k_next     = '0;
                        n_next     = '0;
                        s_next     = '0;
                    end
                end
            end
            S_COF:
            begin
                s_next = s_reg + 4'd1;
                case (s_reg)
                    4'd0:
                    begin
                        cmd.op    = OP_LDY_E;
                        cmd.addr  = {rs2, cq};
                        cmd.clr_t = 1'b1;
                        cmd.clr_m = (n_reg == 2'd0);
                    end
                    4'd1:
                    begin
                        cmd.op   = OP_MAC_T;
                        cmd.addr = {rs1, cp};
                        cmd.top  = 1'b1;
                    end
                    4'd2:
                    begin
                        cmd.op   = OP_LDY_E;
                        cmd.addr = {rs2, cp};
                    end
                    4'd3:
                    begin
                        cmd.op   = OP_MAC_T;
                        cmd.addr = {rs1, cq};
                        cmd.neg  = 1'b1;
                        cmd.top  = 1'b1;
                    end
                    4'd5:
                        cmd.op = OP_LDY_T;
                    4'd6, 4'd7, 4'd8:
                    begin
                        cmd.op    = OP_MAC_M;
                        cmd.addr  = {rs0, cn};
                        cmd.neg   = (n_reg == 2'd1) ^ par;
                        cmd.chunk = 2'(s_reg - 4'd6);
                        cmd.top   = (s_reg == 4'd8);
                        if (s_reg == 4'd8 && n_reg != 2'd2)
                        begin
                            n_next = n_reg + 2'd1;
                            s_next = '0;
                        end
                    end
                    4'd10:
                    begin
                        cmd.adj_wr = 1'b1;
                        n_next     = '0;
                        s_next     = '0;
                        if (k_reg == 4'hF)
                            state_next = S_DET;
                        else
                            k_next = k_reg + 4'd1;
                    end
                    default:
                        cmd.op = OP_NOP;
                endcase
            end
            S_DET:
            begin
                s_next      = s_reg + 4'd1;
                cmd.adj_idx = {n_reg, 2'b00};
                case (s_reg)
                    4'd0:
                    begin
                        cmd.op    = OP_LDY_A;
                        cmd.clr_m = (n_reg == 2'd0);
                    end
                    4'd1, 4'd2, 4'd3, 4'd4:
                    begin
                        cmd.op    = OP_MAC_M;
                        cmd.addr  = {2'b00, n_reg};
                        cmd.chunk = 2'(s_reg - 4'd1);
                        cmd.top   = (s_reg == 4'd4);
                        if (s_reg == 4'd4 && n_reg != 2'd3)
                        begin
                            n_next = n_reg + 2'd1;
                            s_next = '0;
                        end
                    end
                    4'd6:
                    begin
                        cmd.det_ld = 1'b1;
                        k_next     = '0;
                        state_next = S_DSTART;
                    end
                    default:
                        cmd.op = OP_NOP;
                endcase
            end
            S_DSTART:
            begin
                if (stat.singular)
                    state_next = S_EMIT;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DWAIT;
                end
            end
            S_DWAIT:
            begin
                if (stat.div_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_space)
                begin
                    cmd.out_ld = 1'b1;
                    if (k_reg == 4'hF)
                        state_next = S_IDLE;
                    else
                    begin
                        k_next     = k_reg + 4'd1;
                        state_next = S_DSTART;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            n_reg     <= '0;
            s_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
            s_reg     <= s_next;
        end
    end

endmodule

// ----- tb/tb_matrix_inverse_4x4.sv -----
module tb_matrix_inverse_4x4;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [159:0] wide_t;

    typedef struct {
        logic [1:0]         r;
        logic [1:0]         c;
        logic signed [31:0] value;
        logic signed [31:0] det;
        logic               sing;
        logic               sat;
        logic               last;
    } inv_entry_t;

    class inverse_scoreboard;
        logic [31:0] mat [16];
        inv_entry_t  pending [$];
        int          errors;

        function wide_t elem(int r, int c);
            return wide_t'($signed(mat[r * 4 + c]));
        endfunction

        function wide_t cofactor(int r, int c);
            int    rs [3];
            int    cs [3];
            int    n;
            int    m;
            wide_t t;
            wide_t s;
            n = 0;
            for (int k = 0; k < 4; k++)
                if (k != r)
                begin
                    rs[n] = k;
                    n++;
                end
            m = 0;
            for (int k = 0; k < 4; k++)
                if (k != c)
                begin
                    cs[m] = k;
                    m++;
                end
            t = elem(rs[1], cs[1]) * elem(rs[2], cs[2]) - elem(rs[1], cs[2]) * elem(rs[2], cs[1]);
            s = elem(rs[0], cs[0]) * t;
            t = elem(rs[1], cs[0]) * elem(rs[2], cs[2]) - elem(rs[1], cs[2]) * elem(rs[2], cs[0]);
            s = s - elem(rs[0], cs[1]) * t;
            t = elem(rs[1], cs[0]) * elem(rs[2], cs[1]) - elem(rs[1], cs[1]) * elem(rs[2], cs[0]);
            s = s + elem(rs[0], cs[2]) * t;
            return ((r + c) % 2) ? -s : s;
        endfunction

        function logic [31:0] clip32(wide_t a, output logic clipped);
            clipped = 1'b1;
            if (a > wide_t'(32'sh7FFFFFFF))
                return 32'h7FFFFFFF;
            if (a < wide_t'(-33'sd2147483648))
                return 32'h80000000;
            clipped = 1'b0;
            return a[31:0];
        endfunction

        function void note_beat(logic [1:0] r, logic [1:0] c, logic [31:0] v, logic go);
            wide_t        adj [16];
            wide_t        det;
            logic [159:0] dmag;
            logic [159:0] num;
            logic [159:0] quo;
            wide_t        q;
            logic [31:0]  det_q;
            logic         dummy;
            inv_entry_t   e;
            mat[{r, c}] = v;
            if (!go)
                return;
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                    adj[i * 4 + j] = cofactor(j, i);
            det = '0;
            for (int j = 0; j < 4; j++)
                det = det + elem(0, j) * adj[j * 4];
            dmag = (det < 0) ? -det : det;
            q = wide_t'(dmag >> 48);
            if (det < 0)
                q = -q;
            det_q = clip32(q, dummy);
            for (int k = 0; k < 16; k++)
            begin
                e.r = 2'(k / 4);
                e.c = 2'(k % 4);
                e.last = (k == 15);
                e.sing = (det == 0);
                e.sat = 1'b0;
                e.value = '0;
                e.det = '0;
                if (det != 0)
                begin
                    num = (adj[k] < 0) ? -adj[k] : adj[k];
                    num = num << 32;
                    quo = num / dmag;
                    q = wide_t'(quo);
                    if ((adj[k] < 0) != (det < 0))
                        q = -q;
                    e.value = clip32(q, e.sat);
                    e.det = det_q;
                end
                pending.push_back(e);
            end
        endfunction

        function void check_result(inv_entry_t a);
            inv_entry_t x;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result r=%0d c=%0d", a.r, a.c);
                return;
            end
            x = pending.pop_front();
            if (a.r !== x.r || a.c !== x.c || a.value !== x.value || a.det !== x.det
                || a.sing !== x.sing || a.sat !== x.sat || a.last !== x.last)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch exp r%0d c%0d v=%h d=%h s=%b t=%b l=%b got r%0d c%0d v=%h d=%h s=%b t=%b l=%b",
                             x.r, x.c, x.value, x.det, x.sing, x.sat, x.last,
                             a.r, a.c, a.value, a.det, a.sing, a.sat, a.last);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] entry_value;
    logic               go;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         out_row;
    logic [1:0]         out_col;
    logic signed [31:0] inverse_value;
    logic signed [31:0] determinant;
    logic               singular;
    logic               saturated;
    logic               last;

    inverse_scoreboard sb;
    int                beats_sent;
    logic              random_phase;
    logic              quiet;

    matrix_inverse_4x4 dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .row(row), .col(col), .entry_value(entry_value), .go(go),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_row(out_row), .out_col(out_col), .inverse_value(inverse_value),
        .determinant(determinant), .singular(singular), .saturated(saturated),
        .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(8 * 2000000);
        $display("matrix_inverse_4x4 test failed");
        $finish;
    end

    task automatic send_beat(logic [1:0] r, logic [1:0] c, logic [31:0] v, logic g);
        int gap;
        if (random_phase && !quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid = 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        row = r;
        col = c;
        entry_value = v;
        go = g;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_beat(r, c, v, g);
        beats_sent++;
        quiet = (beats_sent >= 400);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_entry();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            2: return $urandom_range(0, 3) == 0 ? 32'h0 : $urandom_range(0, 1) ? 32'h1 : 32'hFFFFFFFF;
            default: return ($urandom_range(0, 8) - 4) * 32'sd65536 + $signed($urandom_range(0, 16383)) - 8192;
        endcase
    endfunction

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        row = '0;
        col = '0;
        entry_value = '0;
        go = 1'b0;
        beats_sent = 0;
        random_phase = 1'b0;
        quiet = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // identity, then small / extreme diagonals, negative and singular cases
        for (int k = 0; k < 16; k++)
            send_beat(2'(k / 4), 2'(k % 4), (k / 4 == k % 4) ? 32'sd65536 : 32'sd0, k == 15);
        send_beat(2'd0, 2'd0, 32'h1, 1'b1);
        send_beat(2'd2, 2'd2, 32'h80000000, 1'b1);
        send_beat(2'd3, 2'd3, 32'h7FFFFFFF, 1'b1);
        send_beat(2'd0, 2'd3, -32'sd65536, 1'b1);
        send_beat(2'd1, 2'd1, 32'h0, 1'b1);

        random_phase = 1'b1;
        while (beats_sent < 450)
        begin
            int n;
            int zr;
            if ($urandom_range(0, 9) == 0)
            begin
                zr = $urandom_range(0, 3);
                for (int c = 0; c < 4; c++)
                    send_beat(2'(zr), 2'(c), 32'h0, c == 3);
            end
            else
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    send_beat(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), rand_entry(),
                              i == n - 1);
            end
        end
        in_valid = 1'b0;
        go = 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("matrix_inverse_4x4 test passed");
        else
            $display("matrix_inverse_4x4 test failed");
        $finish;
    end

    initial
    begin
        int gap;
        logic held;
        held = 1'b0;
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (random_phase && !held)
            begin
                held = 1'b1;
                out_ready = 1'b0;
                repeat (4000) @(negedge clk);
            end
            if (random_phase && !quiet && $urandom_range(0, 4) == 0)
            begin
                out_ready = 1'b0;
                gap = $urandom_range(1, 4);
                repeat (gap - 1) @(negedge clk);
            end
            else
                out_ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        inv_entry_t a;
        if (rst_n && out_valid && out_ready)
        begin
            a.r = out_row;
            a.c = out_col;
            a.value = inverse_value;
            a.det = determinant;
            a.sing = singular;
            a.sat = saturated;
            a.last = last;
            sb.check_result(a);
        end
    end

endmodule
